FILE: rtl/cdq_pkg.sv
// shared widths, reset values and operation codes of the circular deque
package cdq_pkg;

   // payload field widths
   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;

   // capacity register
   localparam int              CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register port
   localparam int   APB_ADDR_W       = 3;
   localparam int   APB_DATA_W       = 32;
   localparam int   CSR_IDX_BIT      = 2;
   localparam logic CSR_REG_CAPACITY = 1'b0;

   // default build
   localparam int DEPTH_DEFAULT  = 16;
   localparam int DATA_W_DEFAULT = 32;

   // operation codes carried in mode
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_REAR  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_REAR   = 3'd3,
      MODE_QUERY      = 3'd4
   } mode_type;

endpackage

FILE: rtl/cdq_if.sv
// request and response channel interfaces of the circular deque

interface cdq_req_if;
   import cdq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [VALUE_W-1:0] item_value;

   modport source (output valid, mode, item_value, input ready);
   modport sink   (input valid, mode, item_value, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      accepted;
   logic signed [VALUE_W-1:0] front_value;
   logic signed [VALUE_W-1:0] rear_value;
   logic                      is_empty;
   logic                      is_full;

   modport source (output valid, accepted, front_value, rear_value, is_empty, is_full,
                   input ready);
   modport sink   (input valid, accepted, front_value, rear_value, is_empty, is_full,
                   output ready);
endinterface

FILE: rtl/cdq_cell.sv
// one storage cell of the deque row: holds a word and forwards front and rear reads
module cdq_cell #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEFAULT,
   parameter int POS        = 0
) (
   input  logic                                                clock,
   input  logic                                                wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]        wr_idx,
   input  logic [DATA_WIDTH-1:0]                               wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]        front_idx,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]        rear_idx,
   input  logic [DATA_WIDTH-1:0]                               front_in,
   input  logic [DATA_WIDTH-1:0]                               rear_in,
   output logic [DATA_WIDTH-1:0]                               front_out,
   output logic [DATA_WIDTH-1:0]                               rear_out
);
   import cdq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_WIDTH-1:0] entry_ff;
   logic                  front_hit;
   logic                  rear_hit;

   // entry storage, written when the write index lands on this cell
   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == IDX_W'(POS))) begin
         entry_ff <= wr_data;
      end
   end

   // read chain: merge this word in when an end points here
   assign front_hit = (front_idx == IDX_W'(POS));
   assign rear_hit  = (rear_idx == IDX_W'(POS));
   assign front_out = front_in | (entry_ff & {DATA_WIDTH{front_hit}});
   assign rear_out  = rear_in | (entry_ff & {DATA_WIDTH{rear_hit}});

endmodule

FILE: rtl/cdq_ctrl.sv
// front and rear indexes, entry count and operation decode of the deque
module cdq_ctrl #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         accept,
   input  logic [cdq_pkg::MODE_W-1:0]                   mode,
   input  logic [cdq_pkg::CAP_W-1:0]                    capacity,
   output logic                                         ok,
   output logic                                         wr_en,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] front_idx,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rear_idx,
   output logic                                         empty,
   output logic                                         full
);
   import cdq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_eff;
   logic             write_c;

   // index one slot up, wrapping at the capacity
   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      if (nxt >= cap) begin
         return '0;
      end
      return IDX_W'(nxt);
   endfunction

   // index one slot down, wrapping to the top of the capacity
   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
      if ((idx == '0) || (CNT_W'(idx) > cap)) begin
         return IDX_W'(cap - CNT_W'(1));
      end
      return idx - IDX_W'(1);
   endfunction

   // usable capacity: zero reads as one, clipped to the built depth
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(capacity) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
   end

   // operation decode and next indexes
   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      count_in = count_ff;
      write_c  = 1'b0;
      wr_idx   = front_ff;
      ok       = 1'b0;
      case (mode)
         MODE_PUSH_FRONT: begin
            if (count_ff < cap_eff) begin
               ok       = 1'b1;
               write_c  = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (count_ff == '0) begin
                  rear_in = front_ff;
                  wr_idx  = front_ff;
               end else begin
                  front_in = step_down(front_ff, cap_eff);
                  wr_idx   = front_in;
               end
            end
         end
         MODE_PUSH_REAR: begin
            if (count_ff < cap_eff) begin
               ok       = 1'b1;
               write_c  = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (count_ff == '0) begin
                  front_in = rear_ff;
                  wr_idx   = rear_ff;
               end else begin
                  rear_in = step_up(rear_ff, cap_eff);
                  wr_idx  = rear_in;
               end
            end
         end
         MODE_POP_FRONT: begin
            if (count_ff != '0) begin
               ok       = 1'b1;
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  rear_in = front_ff;
               end else begin
                  front_in = step_up(front_ff, cap_eff);
               end
            end
         end
         MODE_POP_REAR: begin
            if (count_ff != '0) begin
               ok       = 1'b1;
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  front_in = rear_ff;
               end else begin
                  rear_in = step_down(rear_ff, cap_eff);
               end
            end
         end
         MODE_QUERY: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // state registers, moved only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   // status towards the row and the result register
   assign wr_en     = accept & write_c;
   assign front_idx = front_ff;
   assign rear_idx  = rear_ff;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff >= cap_eff);

endmodule

FILE: rtl/circular_deque_top.sv
// top level of the circular deque: register port, control, cell row and result register
//
// Double-ended queue of DEPTH words held in a row of storage cells, of which the
// capacity register (byte address 0, reset 16) lets up to that many be used. Each
// request beat is applied to the indexes and the row at the edge it is accepted,
// and is held in the pending stage until its response is loaded into the result
// register; a new request is taken every cycle as long as the result register
// is free or being emptied. The front and rear words are gathered by an OR chain
// that runs through the whole row of cells, which sets the read path length at
// DEPTH cells. The capacity must only be written while no request is in flight;
// the row needs no clearing after reset.
module circular_deque_top #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   cdq_req_if.sink                          req_chan,
   cdq_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cdq_pkg::APB_ADDR_W-1:0]   paddr,
   input  logic [cdq_pkg::APB_DATA_W-1:0]   pwdata,
   output logic [cdq_pkg::APB_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import cdq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic                  cap_wr;
   logic                  accept;
   logic                  load;
   logic                  pending_ff, pending_in;
   logic                  ok_ff, ok_in;
   logic                  ok_c;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [IDX_W-1:0]      front_idx;
   logic [IDX_W-1:0]      rear_idx;
   logic                  empty_c;
   logic                  full_c;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] front_chain [DEPTH+1];
   logic [DATA_WIDTH-1:0] rear_chain [DEPTH+1];
   logic [DATA_WIDTH-1:0] ones_word;
   logic [VALUE_W-1:0]    front_word;
   logic [VALUE_W-1:0]    rear_word;
   logic [VALUE_W-1:0]    empty_word;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff;
   logic [VALUE_W-1:0]    rsp_front_ff, rsp_front_in;
   logic [VALUE_W-1:0]    rsp_rear_ff, rsp_rear_in;
   logic                  rsp_empty_ff;
   logic                  rsp_full_ff;

   // capacity register
   assign pready = 1'b1;
   assign cap_wr = psel & penable & pwrite & pready & (paddr[CSR_IDX_BIT] == CSR_REG_CAPACITY);
   assign cap_in = cap_wr ? pwdata[CAP_W-1:0] : cap_ff;
   assign prdata = (paddr[CSR_IDX_BIT] == CSR_REG_CAPACITY) ? APB_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // request handshake: one beat waits for the result register at most
   assign load           = pending_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~pending_ff | load;
   assign accept         = req_chan.valid & req_chan.ready;
   assign pending_in     = accept | (pending_ff & ~load);
   assign ok_in          = accept ? ok_c : ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
   end

   // index and count control
   cdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_chan.mode),
      .capacity  (cap_ff),
      .ok        (ok_c),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .front_idx (front_idx),
      .rear_idx  (rear_idx),
      .empty     (empty_c),
      .full      (full_c)
   );

   // word width conversion between the ports and the row
   assign ones_word = '1;
   generate
      if (DATA_WIDTH >= VALUE_W) begin : g_wide
         assign wr_data    = DATA_WIDTH'(req_chan.item_value[VALUE_W-1:0]);
         assign front_word = front_chain[DEPTH][VALUE_W-1:0];
         assign rear_word  = rear_chain[DEPTH][VALUE_W-1:0];
         assign empty_word = ones_word[VALUE_W-1:0];
      end else begin : g_narrow
         assign wr_data    = req_chan.item_value[DATA_WIDTH-1:0];
         assign front_word = VALUE_W'(front_chain[DEPTH]);
         assign rear_word  = VALUE_W'(rear_chain[DEPTH]);
         assign empty_word = VALUE_W'(ones_word);
      end
   endgenerate

   // row of storage cells, read chain running from cell 0 upwards
   assign front_chain[0] = '0;
   assign rear_chain[0]  = '0;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         cdq_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .POS        (i)
         ) u_cell (
            .clock     (clock),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_data   (wr_data),
            .front_idx (front_idx),
            .rear_idx  (rear_idx),
            .front_in  (front_chain[i]),
            .rear_in   (rear_chain[i]),
            .front_out (front_chain[i+1]),
            .rear_out  (rear_chain[i+1])
         );
      end
   endgenerate

   // result register
   assign rsp_front_in = empty_c ? empty_word : front_word;
   assign rsp_rear_in  = empty_c ? empty_word : rear_word;
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_accepted_ff <= ok_ff;
         rsp_front_ff    <= rsp_front_in;
         rsp_rear_ff     <= rsp_rear_in;
         rsp_empty_ff    <= empty_c;
         rsp_full_ff     <= full_c;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accepted    = rsp_accepted_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.rear_value  = rsp_rear_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.is_full     = rsp_full_ff;

`ifndef ASSERT_OFF
   // a response only appears after a beat was applied
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pending_ff))
      else $error("response raised without an applied request");

   // an applied beat stays pending until its result is captured
   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      pending_ff && !load |=> pending_ff)
      else $error("pending beat dropped before capture");

   // an empty deque is never reported full
   a_empty_not_full: assert property (@(posedge clock) disable iff (reset)
      empty_c |-> !full_c)
      else $error("deque reported empty and full together");
`endif

endmodule

FILE: bench/tb_circular_deque_top.sv
// testbench of the circular deque: a directed table, then random phases, every beat checked
`timescale 1ns / 100ps

module tb_circular_deque_top;
   import cdq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;

   // modes outside the defined set
   localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = 3'd7;

   // register addresses: capacity, and the unused slot after it
   localparam logic [APB_ADDR_W-1:0] CAP_ADDR =
      APB_ADDR_W'(CSR_REG_CAPACITY) << CSR_IDX_BIT;
   localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = CAP_ADDR | APB_ADDR_W'(1 << CSR_IDX_BIT);

   localparam int HOLD_CYCLES = 60;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 125;
   localparam int TIMEOUT_NS  = 5_000_000;

   typedef struct packed {
      logic               accepted;
      logic [VALUE_W-1:0] front_value;
      logic [VALUE_W-1:0] rear_value;
      logic               is_empty;
      logic               is_full;
   } deque_result_type;

   typedef enum {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [MODE_W-1:0]  mode;
      logic [31:0]        value;
      bit                 typed;
      deque_result_type   want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_deque_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // clock
   always #10 clock = ~clock;

   // deque predictor state
   logic [VALUE_W-1:0] dq_slots [DEPTH];
   int unsigned        head_idx;
   int unsigned        tail_idx;
   int unsigned        fill_count;
   logic [CAP_W-1:0]   cap_reg;

   // expected responses, oldest first
   deque_result_type pending [$];

   // idling control shared by both sides
   int unsigned req_gap_max = 5;
   int unsigned rsp_gap_max = 5;
   bit          hold_req    = 1'b0;

   // run statistics
   int unsigned mismatch_count = 0;
   int unsigned req_count      = 0;
   int unsigned rsp_count      = 0;
   int unsigned push_refused   = 0;
   int unsigned pop_refused    = 0;
   int unsigned full_seen      = 0;
   int unsigned empty_seen     = 0;
   int unsigned cap_writes     = 0;

   // receiver state
   deque_result_type oldest;
   int unsigned      rsp_wait  = 0;
   int unsigned      hold_left = 0;

   // index step towards the rear, wrapping at the capacity
   function automatic int unsigned idx_up(input int unsigned idx, input int unsigned cap);
      int unsigned n;
      n = idx + 1;
      return (n >= cap) ? 0 : n;
   endfunction

   // index step towards the front; an index past the capacity lands on its last slot
   function automatic int unsigned idx_down(input int unsigned idx, input int unsigned cap);
      if (idx == 0) return cap - 1;
      if (idx > cap) return cap - 1;
      return idx - 1;
   endfunction

   // apply one request beat to the predictor and return the response it gives
   function automatic deque_result_type deque_apply(input logic [MODE_W-1:0] op,
                                                    input logic [VALUE_W-1:0] word);
      deque_result_type res;
      int unsigned      cap;
      logic             ok;
      if (cap_reg == 0) cap = 1;
      else if (cap_reg > DEPTH) cap = DEPTH;
      else cap = 32'(cap_reg);
      ok = 1'b0;
      case (op)
         MODE_PUSH_FRONT: begin
            if (fill_count < cap) begin
               if (fill_count == 0) tail_idx = head_idx;
               else head_idx = idx_down(head_idx, cap);
               dq_slots[head_idx] = word;
               fill_count++;
               ok = 1'b1;
            end
         end
         MODE_PUSH_REAR: begin
            if (fill_count < cap) begin
               if (fill_count == 0) head_idx = tail_idx;
               else tail_idx = idx_up(tail_idx, cap);
               dq_slots[tail_idx] = word;
               fill_count++;
               ok = 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (fill_count != 0) begin
               if (fill_count == 1) tail_idx = head_idx;
               else head_idx = idx_up(head_idx, cap);
               fill_count--;
               ok = 1'b1;
            end
         end
         MODE_POP_REAR: begin
            if (fill_count != 0) begin
               if (fill_count == 1) head_idx = tail_idx;
               else tail_idx = idx_down(tail_idx, cap);
               fill_count--;
               ok = 1'b1;
            end
         end
         MODE_QUERY: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      res.accepted    = ok;
      res.front_value = (fill_count == 0) ? {VALUE_W{1'b1}} : dq_slots[head_idx];
      res.rear_value  = (fill_count == 0) ? {VALUE_W{1'b1}} : dq_slots[tail_idx];
      res.is_empty    = (fill_count == 0);
      res.is_full     = (fill_count >= cap);
      return res;
   endfunction

   function automatic stim_row_type row(input row_kind_type kind,
                                        input logic [MODE_W-1:0] mode,
                                        input logic [31:0] value, input bit typed,
                                        input deque_result_type want);
      stim_row_type r;
      r.kind  = kind;
      r.mode  = mode;
      r.value = value;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // one register access: setup phase, access phase held until pready, then the port is left idle
   task automatic csr_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] wdata,
                             output logic [APB_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering beats and wait until every response is back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write while idle, followed by a read-back of the capacity
   task automatic csr_write_checked(input logic [APB_ADDR_W-1:0] addr,
                                    input logic [APB_DATA_W-1:0] data);
      logic [APB_DATA_W-1:0] rd;
      wait_drained();
      csr_access(1'b1, addr, data, rd);
      if (addr == CAP_ADDR) begin
         cap_reg = data[CAP_W-1:0];
         cap_writes++;
      end
      csr_access(1'b0, CAP_ADDR, '0, rd);
      if (rd !== APB_DATA_W'(cap_reg)) begin
         $display("%0t: capacity read-back, expected %h, actual %h", $time,
                  APB_DATA_W'(cap_reg), rd);
         mismatch_count++;
      end
   endtask

   // offer one request beat after a random gap; predict its response once taken
   task automatic send_op(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v,
                          input bit typed, input deque_result_type want);
      deque_result_type res;
      int unsigned      gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= m;
      req_bus.item_value <= v;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      res = deque_apply(m, v);
      req_count++;
      if (!res.accepted && (m == MODE_PUSH_FRONT || m == MODE_PUSH_REAR)) push_refused++;
      if (!res.accepted && (m == MODE_POP_FRONT || m == MODE_POP_REAR)) pop_refused++;
      if (res.is_full) full_seen++;
      if (res.is_empty) empty_seen++;
      pending.push_back(typed ? want : res);
   endtask

   // receiver: checks each response beat, stalls at random and on request for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait  = 0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            rsp_count++;
            if (pending.size() == 0) begin
               $display("%0t: response beat with nothing expected, actual %b %h %h %b %b",
                        $time, rsp_bus.accepted, rsp_bus.front_value, rsp_bus.rear_value,
                        rsp_bus.is_empty, rsp_bus.is_full);
               mismatch_count++;
            end else begin
               oldest = pending.pop_front();
               compare_field("accepted", VALUE_W'(oldest.accepted),
                             VALUE_W'(rsp_bus.accepted));
               compare_field("front_value", oldest.front_value, rsp_bus.front_value);
               compare_field("rear_value", oldest.rear_value, rsp_bus.rear_value);
               compare_field("is_empty", VALUE_W'(oldest.is_empty),
                             VALUE_W'(rsp_bus.is_empty));
               compare_field("is_full", VALUE_W'(oldest.is_full),
                             VALUE_W'(rsp_bus.is_full));
            end
            rsp_wait = $urandom_range(0, rsp_gap_max);
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      stim_row_type       dir_table [$];
      int unsigned        caps [PHASES];
      logic [31:0]        wdata;
      logic [MODE_W-1:0]  m;
      logic [VALUE_W-1:0] v;
      int unsigned        seg_left;
      int unsigned        push_pct;
      int unsigned        pick;

      // known values on every input from the start
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_QUERY;
      req_bus.item_value = '0;
      rsp_bus.ready      = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = CAP_ADDR;
      pwdata             = '0;

      // predictor after reset
      foreach (dq_slots[i]) dq_slots[i] = '0;
      head_idx   = 0;
      tail_idx   = 0;
      fill_count = 0;
      cap_reg    = CAP_RESET;

      // directed table: empty deque, extremes, fill to full, capacity corner cases
      dir_table.push_back(row(ROW_ITEM, MODE_QUERY, 32'h0, 1'b1,
                              {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}));
      dir_table.push_back(row(ROW_ITEM, MODE_POP_FRONT, 32'h0, 1'b1,
                              {1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}));
      dir_table.push_back(row(ROW_ITEM, MODE_UNKNOWN_HI, 32'h0, 1'b1,
                              {1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}));
      dir_table.push_back(row(ROW_ITEM, MODE_PUSH_REAR, 32'h7FFF_FFFF, 1'b1,
                              {1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0}));
      dir_table.push_back(row(ROW_ITEM, MODE_PUSH_FRONT, 32'h8000_0000, 1'b1,
                              {1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}));
      for (int k = 0; k < 12; k++)
         dir_table.push_back(row(ROW_ITEM, (k % 2) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
                                 $urandom, 1'b0, '0));
      dir_table.push_back(row(ROW_ITEM, MODE_PUSH_FRONT, 32'h0, 1'b0, '0));
      dir_table.push_back(row(ROW_ITEM, MODE_PUSH_REAR, 32'hFFFF_FFFF, 1'b0, '0));
      // full: both pushes refused
      dir_table.push_back(row(ROW_ITEM, MODE_PUSH_REAR, 32'h1234_5678, 1'b1,
                              {1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1}));
      dir_table.push_back(row(ROW_ITEM, MODE_PUSH_FRONT, 32'h1234_5678, 1'b1,
                              {1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1}));
      // capacity lowered below the count
      dir_table.push_back(row(ROW_CAPACITY, MODE_QUERY, 32'd4, 1'b0, '0));
      dir_table.push_back(row(ROW_ITEM, MODE_PUSH_REAR, 32'h5A5A_A5A5, 1'b1,
                              {1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1}));
      dir_table.push_back(row(ROW_ITEM, MODE_POP_FRONT, 32'h0, 1'b0, '0));
      // capacity zero, then above the depth
      dir_table.push_back(row(ROW_CAPACITY, MODE_QUERY, 32'd0, 1'b0, '0));
      dir_table.push_back(row(ROW_ITEM, MODE_QUERY, 32'h0, 1'b0, '0));
      dir_table.push_back(row(ROW_CAPACITY, MODE_QUERY, 32'd31, 1'b0, '0));
      dir_table.push_back(row(ROW_ITEM, MODE_POP_REAR, 32'h0, 1'b0, '0));

      // reset
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // write to the unused address must leave the capacity at its reset value
      csr_write_checked(SPARE_ADDR, $urandom);

      // directed part
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CAPACITY)
            csr_write_checked(CAP_ADDR, dir_table[i].value);
         else
            send_op(dir_table[i].mode, dir_table[i].value, dir_table[i].typed,
                    dir_table[i].want);
      end

      // random phases, each under its own capacity
      caps = '{16, 1, 0, 31, $urandom_range(2, 15), 16, $urandom_range(2, 15), 2,
               $urandom_range(17, 30), 15, $urandom_range(2, 15), 16};
      push_pct = 20;
      for (int phase = 0; phase < PHASES; phase++) begin
         wdata = $urandom;
         wdata[CAP_W-1:0] = CAP_W'(caps[phase]);
         csr_write_checked(CAP_ADDR, wdata);
         req_gap_max = (phase % 3 == 0) ? 0 : 5;
         rsp_gap_max = (phase % 4 == 1) ? 0 : 5;
         // back-pressure: receiver holds off while the sender keeps offering
         if (phase == 2 || phase == 7) begin
            req_gap_max = 0;
            hold_req    = 1'b1;
         end
         seg_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender pause until everything is back
            if (phase == 4 && n == PHASE_ITEMS / 2) wait_drained();
            // alternate push-heavy and pop-heavy runs so both full and empty are reached
            if (seg_left == 0) begin
               seg_left = $urandom_range(8, 40);
               push_pct = (push_pct > 50) ? 20 : 80;
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) m = MODE_W'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
            else if (pick < 10) m = MODE_QUERY;
            else if ($urandom_range(0, 99) < push_pct)
               m = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else
               m = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
            case ($urandom_range(0, 9))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0;
               3: v = 32'hFFFF_FFFF;
               default: v = $urandom;
            endcase
            send_op(m, v, 1'b0, '0);
         end
      end

      // drain and settle
      wait_drained();
      repeat (5) @(posedge clock);
      $display("run covered %0d request beats and %0d response beats under %0d capacity writes",
               req_count, rsp_count, cap_writes);
      $display("deque full on %0d and empty on %0d responses; %0d pushes, %0d pops refused",
               full_seen, empty_seen, push_refused, pop_refused);
      if (mismatch_count == 0 && pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout, %0d responses still outstanding", $time, pending.size());
      $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_cell.sv
rtl/cdq_ctrl.sv
rtl/circular_deque_top.sv
bench/tb_circular_deque_top.sv
